/* hw/rtl/rip_pkg.sv */
// ----------------------------------------------------------------------------
// rip_pkg: shared types and constants of the radix integer parser
// Configuration layout, register indexes, word types and parse phases.
// ----------------------------------------------------------------------------
package rip_pkg;

    localparam int CH_W       = 8;
    localparam int VALUE_W    = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_PLUS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_LZ   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_SEL  = 3'd4;

    // Reset values of the configuration
    localparam logic [5:0] RADIX_RST     = 6'd10;
    localparam logic [1:0] WIDTH_SEL_RST = 2'd3;

    // ASCII codes the parser looks for
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_UA    = 8'h41;
    localparam logic [CH_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CH_W-1:0] CH_LA    = 8'h61;
    localparam logic [CH_W-1:0] CH_LZ    = 8'h7A;
    localparam logic [CH_W-1:0] DIGIT_BAD = 8'hFF;

    typedef struct packed {
        logic [5:0] radix;
        logic       allow_plus;
        logic       allow_leading_zero;
        logic       signed_mode;
        logic [1:0] width_select;
    } t_cfg;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            last;
    } t_char;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               ok;
    } t_result;

    typedef enum logic [1:0] {
        PH_START,
        PH_SIGN,
        PH_DIGITS
    } t_phase;

endpackage

/* hw/rtl/rip_if.sv */
// ----------------------------------------------------------------------------
// rip_if: valid/ready channels of the radix integer parser
// One channel carries characters, the other carries parse results.
// ----------------------------------------------------------------------------
interface rip_char_if import rip_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;
    logic            last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

interface rip_result_if import rip_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               ok;

    modport source (output valid, output value, output ok, input ready);
    modport sink   (input valid, input value, input ok, output ready);
endinterface

/* hw/rtl/rip_in_stage.sv */
// ----------------------------------------------------------------------------
// rip_in_stage: character input register
// Holds one accepted character word until the parse stage consumes it.
// ----------------------------------------------------------------------------
module rip_in_stage import rip_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rip_char_if.sink      i_char,
    input  logic          i_advance,
    output logic          o_valid,
    output t_char         o_word
);

    logic  r_valid;
    logic  n_valid;
    t_char r_word;

    // Free when empty or when the held word moves on this cycle
    assign i_char.ready = !r_valid || i_advance;
    assign n_valid      = i_char.valid || (r_valid && !i_advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload: load on accept
    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_word.ch   <= i_char.ch;
            r_word.last <= i_char.last;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

/* hw/rtl/rip_parse.sv */
// ----------------------------------------------------------------------------
// rip_parse: per-character parse step
// Sign handling, digit decode, multiply-accumulate with range check, and
// the final two's complement result on the last character.
// ----------------------------------------------------------------------------
module rip_parse import rip_pkg::*; #(
    parameter int AW = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_valid,
    input  t_char   i_word,
    input  logic    i_out_free,
    output logic    o_advance,
    output logic    o_load,
    output t_result o_result
);

    localparam int PW = AW + 7;

    // Digit value of a character, case-insensitive letters
    function automatic logic [CH_W-1:0] digit_of(input logic [CH_W-1:0] c);
        logic [CH_W-1:0] d;
        d = DIGIT_BAD;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO;
        end else if (c >= CH_LA && c <= CH_LZ) begin
            d = c - CH_LA + 8'd10;
        end else if (c >= CH_UA && c <= CH_UZ) begin
            d = c - CH_UA + 8'd10;
        end
        return d;
    endfunction

    logic [AW-1:0] r_acc, n_acc;
    t_phase        r_phase, n_phase;
    logic          r_neg, n_neg;
    logic          r_failed, n_failed;
    logic          r_zls, n_zls;

    logic [CH_W-1:0] digit;
    logic            digit_ok;
    logic [6:0]      width_base, eff_w;
    logic [AW-1:0]   mask_w, lim_w, mag_w;
    logic [PW-1:0]   prod;
    logic            take_ok;
    logic            at_start, pre_digit, sign_plus, sign_minus;

    assign o_advance = i_valid && (!i_word.last || i_out_free);
    assign o_load    = o_advance && i_word.last;

    // Effective width and magnitude limit
    assign width_base = 7'd8 << i_cfg.width_select;
    assign eff_w      = (width_base > 7'(AW)) ? 7'(AW) : width_base;
    assign mask_w     = {AW{1'b1}} >> (7'(AW) - eff_w);

    always_comb begin
        if (!i_cfg.signed_mode && !r_neg) begin
            lim_w = mask_w;
        end else if (r_neg) begin
            lim_w = {{(AW-1){1'b0}}, 1'b1} << (eff_w - 7'd1);
        end else begin
            lim_w = mask_w >> 1;
        end
    end

    // Digit check and multiply-accumulate; overflow when result passes limit
    assign digit    = digit_of(i_word.ch);
    assign digit_ok = digit < {2'b00, i_cfg.radix};
    assign prod     = PW'(r_acc) * PW'(i_cfg.radix) + PW'(digit);
    assign take_ok  = digit_ok && (prod <= PW'(lim_w));

    assign at_start   = (r_phase == PH_START);
    assign pre_digit  = at_start || (r_phase == PH_SIGN);
    assign sign_plus  = at_start && (i_word.ch == CH_PLUS);
    assign sign_minus = at_start && (i_word.ch == CH_MINUS) && i_cfg.signed_mode;

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (!r_failed) begin
            priority if (sign_plus) begin
                if (i_cfg.allow_plus) n_phase = PH_SIGN;
            end else if (sign_minus) begin
                n_phase = PH_SIGN;
            end else if (pre_digit) begin
                n_phase = PH_DIGITS;
            end else begin
                n_phase = r_phase;
            end
        end
    end

    // Next accumulator and flags
    always_comb begin
        n_acc    = r_acc;
        n_neg    = r_neg;
        n_failed = r_failed;
        n_zls    = r_zls;
        if (!r_failed) begin
            priority if (sign_plus) begin
                if (!i_cfg.allow_plus) n_failed = 1'b1;
            end else if (sign_minus) begin
                n_neg = 1'b1;
            end else if (pre_digit) begin
                if (!take_ok) begin
                    n_failed = 1'b1;
                end else begin
                    n_acc = prod[AW-1:0];
                    if (i_word.ch == CH_ZERO && !i_cfg.allow_leading_zero) n_zls = 1'b1;
                end
            end else if (r_zls) begin
                // more characters after a forbidden leading zero
                n_failed = 1'b1;
            end else if (!take_ok) begin
                n_failed = 1'b1;
            end else begin
                n_acc = prod[AW-1:0];
            end
        end
    end

    // Result word from the updated state
    assign mag_w           = n_neg ? (AW'(0) - n_acc) : n_acc;
    assign o_result.value  = n_failed ? '0 : VALUE_W'(mag_w & mask_w);
    assign o_result.ok     = !n_failed;

    // State registers; cleared at the end of each string
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_phase  <= PH_START;
            r_neg    <= 1'b0;
            r_failed <= 1'b0;
            r_zls    <= 1'b0;
        end else if (o_advance) begin
            if (i_word.last) begin
                r_acc    <= '0;
                r_phase  <= PH_START;
                r_neg    <= 1'b0;
                r_failed <= 1'b0;
                r_zls    <= 1'b0;
            end else begin
                r_acc    <= n_acc;
                r_phase  <= n_phase;
                r_neg    <= n_neg;
                r_failed <= n_failed;
                r_zls    <= n_zls;
            end
        end
    end

    // Checks
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load |-> i_out_free)
        else $error("result loaded while output register is full");
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load |=> (r_phase == PH_START) && (r_acc == '0) && !r_failed && !r_neg)
        else $error("string state not cleared after last character");
    a_zls_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_zls |-> (r_phase == PH_DIGITS))
        else $error("leading zero flag outside digit phase");
    a_neg_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_neg |-> (r_phase != PH_START))
        else $error("negative flag set before any sign");

endmodule

/* hw/rtl/rip_out_stage.sv */
// ----------------------------------------------------------------------------
// rip_out_stage: result output register
// Holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module rip_out_stage import rip_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  t_result       i_result,
    output logic          o_free,
    rip_result_if.source  o_result
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_free  = !r_valid || o_result.ready;
    assign n_valid = i_load || (r_valid && !o_result.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_result.valid = r_valid;
    assign o_result.value = r_result.value;
    assign o_result.ok    = r_result.ok;

endmodule

/* hw/rtl/radix_integer_parser.sv */
// ----------------------------------------------------------------------------
// radix_integer_parser: streaming ASCII to integer converter
// Parses one number string per packet in a configured radix and width.
// ----------------------------------------------------------------------------
// Usage:
//   i_char carries one character word per handshake, with last set on the
//   final character of a string. o_result carries one word per string:
//   value (zero extended, two's complement when negative) and ok.
//   Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data
//   while no string is in flight; unknown indexes are ignored.
// Timing:
//   One character per cycle unless a held result blocks a last character.
//   A character waits in the input register; the parse step (digit decode,
//   multiply by radix, add, limit compare) runs from there to the result
//   register, loaded as the last character leaves the input register.
//   That single multiply-accumulate loop on the accumulator sets the rate.
// Reset:
//   Synchronous, active low; configuration returns to radix 10, unsigned,
//   64-bit, no plus sign, no leading zero, and string state is cleared.
// Stall:
//   A held result blocks only a last character; other characters of the
//   next string keep flowing into the accumulator.
// ----------------------------------------------------------------------------
module radix_integer_parser import rip_pkg::*; #(
    parameter int MAX_WIDTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    rip_char_if.sink              i_char,
    rip_result_if.source          o_result
);

    t_cfg    r_cfg;
    logic    held_valid;
    t_char   held_word;
    logic    advance;
    logic    out_free;
    logic    load;
    t_result result;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radix              <= RADIX_RST;
            r_cfg.allow_plus         <= 1'b0;
            r_cfg.allow_leading_zero <= 1'b0;
            r_cfg.signed_mode        <= 1'b0;
            r_cfg.width_select       <= WIDTH_SEL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RADIX:      r_cfg.radix              <= i_cfg_data;
                CFG_ALLOW_PLUS: r_cfg.allow_plus         <= i_cfg_data[0];
                CFG_ALLOW_LZ:   r_cfg.allow_leading_zero <= i_cfg_data[0];
                CFG_SIGNED:     r_cfg.signed_mode        <= i_cfg_data[0];
                CFG_WIDTH_SEL:  r_cfg.width_select       <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    rip_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_char    (i_char),
        .i_advance (advance),
        .o_valid   (held_valid),
        .o_word    (held_word)
    );

    rip_parse #(
        .AW (MAX_WIDTH)
    ) u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (held_valid),
        .i_word     (held_word),
        .i_out_free (out_free),
        .o_advance  (advance),
        .o_load     (load),
        .o_result   (result)
    );

    rip_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_result (result),
        .o_free   (out_free),
        .o_result (o_result)
    );

endmodule
